// ===== sv/euc_kr_aware_string_escaper_core_macros.svh =====
// Assertion macros for the string escaper checker.
// Depends on nothing; included by the checker file.
`ifndef EUC_KR_AWARE_STRING_ESCAPER_CORE_MACROS_SVH
`define EUC_KR_AWARE_STRING_ESCAPER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escaper check failed");

// Next-cycle implication, disabled during reset.
`define EKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escaper check failed");

`endif

// ===== sv/eks_pkg.sv =====
// Shared types, constants and helpers of the EUC-KR aware string escaper.
// Depends on nothing.
package eks_pkg;

  localparam int unsigned MAX_IN_LEN   = 4096;
  localparam int unsigned LEN_W        = 14;
  localparam int unsigned LEN_FIELD_MX = (1 << LEN_W) - 1;
  localparam int unsigned LEN_TOP_INT  = (2 * MAX_IN_LEN > LEN_FIELD_MX) ?
                                         LEN_FIELD_MX : 2 * MAX_IN_LEN;
  localparam logic [LEN_W-1:0] LEN_TOP = LEN_TOP_INT[LEN_W-1:0];

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] WIDE_LO   = 8'hA1;
  localparam logic [7:0] WIDE_HI   = 8'hFE;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;

  // One accepted item expanded into up to three results.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            abort;
    logic            str_end;
    logic [LEN_W-1:0] len;
  } job_t;

  function automatic logic is_wide(input logic [7:0] b);
    return (b >= WIDE_LO) && (b <= WIDE_HI);
  endfunction

  function automatic logic [7:0] esc_char(input logic [7:0] b);
    logic [7:0] c;
    case (b)
      CH_LF:   c = CH_N;
      CH_CR:   c = CH_R;
      default: c = CH_BSLASH;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/eks_if.sv =====
// Channel interfaces of the string escaper: input bytes and result beats.
// Depends on eks_pkg.
interface eks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface eks_out_if import eks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             run_last;
  logic             string_end;
  logic             aborted;
  logic [LEN_W-1:0] out_length;

  modport source (output valid, out_byte, byte_valid, run_last, string_end, aborted,
                  out_length, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, string_end, aborted,
                  out_length, output ready);
endinterface

// ===== sv/euc_kr_aware_string_escaper_core.sv =====
// EUC-KR aware string escaper, top level.
// Depends on eks_pkg, eks_if, eks_front, eks_queue, eks_back.
//
// in_ch_i takes one source byte per beat; last_byte flags the final byte of
// a string. out_ch_o gives one result beat per cycle while the receiver
// is ready and a job waits: an escaped byte, or a status beat (byte_valid
// 0, aborted 1) when a quote, double quote or tab ends the string.
// run_last marks the last beat caused by an input byte, string_end the last
// beat of a string, which also carries out_length. Results pass through the
// job queue into the output register; an item gives one to three beats (an
// escape after a held lead byte gives three). The input takes a byte per
// cycle while the two-entry job queue has room, and a held lead byte or a
// drained byte gives the back end no job. Reset clears the lead, length and
// drain state, the queue and the output valid flag. When the receiver
// stalls, the output beat holds, the queue fills, and in_ch_i.ready drops
// once both entries are taken.
module euc_kr_aware_string_escaper_core import eks_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  eks_in_if.sink    in_ch_i,
  eks_out_if.source out_ch_o
);

  job_t push_job, head_job;
  logic push, full, pop, empty;

  eks_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch_i),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  eks_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty)
  );

  eks_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (head_job),
    .empty_i  (empty),
    .pop_o    (pop),
    .out_ch_o (out_ch_o)
  );

endmodule

// ===== sv/eks_front.sv =====
// Front end: accepts input bytes, tracks lead byte, length and drain state,
// and turns each item into a result job. Depends on eks_pkg and eks_in_if.
module eks_front import eks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  eks_in_if.sink     in_ch_i,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic             lead_held_q, lead_held_d;
  logic [7:0]       lead_q;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             drain_q, drain_d;

  logic             accept;
  logic [7:0]       b;
  logic             last;
  logic             wide;
  logic [2:0][7:0]  bytes;
  logic [1:0]       nb;
  logic             abort;
  logic             hold;
  logic [LEN_W:0]   sum;
  logic [LEN_W-1:0] sat;

  assign in_ch_i.ready = !full_i;
  assign accept        = in_ch_i.valid && !full_i;
  assign b             = in_ch_i.in_byte;
  assign last          = in_ch_i.last_byte;
  assign wide          = is_wide(b);

  always_comb begin
    bytes = '0;
    nb    = 2'd0;
    abort = 1'b0;
    hold  = 1'b0;
    if (lead_held_q) begin
      bytes[0] = lead_q;
      nb       = 2'd1;
    end
    if (lead_held_q && wide) begin
      bytes[1] = b;
      nb       = 2'd2;
    end else if (b == CH_QUOTE || b == CH_DQUOTE || b == CH_TAB) begin
      abort = 1'b1;
    end else if (b == CH_LF || b == CH_CR || b == CH_BSLASH) begin
      bytes[nb]        = CH_BSLASH;
      bytes[nb + 2'd1] = esc_char(b);
      nb               = nb + 2'd2;
    end else if (wide && !last) begin
      hold = 1'b1;
    end else begin
      bytes[nb] = b;
      nb        = nb + 2'd1;
    end
  end

  assign sum = {1'b0, cnt_q} + {{(LEN_W-1){1'b0}}, nb};
  assign sat = (sum > {1'b0, LEN_TOP}) ? LEN_TOP : sum[LEN_W-1:0];

  always_comb begin
    job_o.cnt     = nb + {1'b0, abort};
    job_o.bytes   = bytes;
    job_o.abort   = abort;
    job_o.str_end = last || abort;
    job_o.len     = (last && !abort) ? sat : '0;
  end

  assign push_o = accept && !drain_q && (job_o.cnt != 2'd0);

  always_comb begin
    lead_held_d = lead_held_q;
    cnt_d       = cnt_q;
    drain_d     = drain_q;
    if (accept) begin
      if (drain_q) begin
        drain_d = !last;
      end else begin
        lead_held_d = hold;
        cnt_d       = (abort || last) ? '0 : sat;
        drain_d     = abort && !last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_held_q <= 1'b0;
      cnt_q       <= '0;
      drain_q     <= 1'b0;
    end else begin
      lead_held_q <= lead_held_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold && !drain_q) begin
      lead_q <= b;
    end
  end

endmodule

// ===== sv/eks_queue.sv =====
// Short job queue between front and back end.
// Depends on eks_pkg.
module eks_queue import eks_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   fill_q;

  assign full_o  = (fill_q == QDEPTH[QPTR_W:0]);
  assign empty_o = (fill_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== sv/eks_back.sv =====
// Back end: steps through the results of the head job and holds each beat
// in the output register. Depends on eks_pkg and eks_out_if.
module eks_back import eks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       empty_i,
  output logic       pop_o,
  eks_out_if.source  out_ch_o
);

  logic             valid_q;
  logic [1:0]       idx_q;
  logic [7:0]       byte_q;
  logic             bvalid_q, run_last_q, end_q, abort_q;
  logic [LEN_W-1:0] len_q;

  logic load, fin, status;

  assign load   = !empty_i && (!valid_q || out_ch_o.ready);
  assign fin    = (idx_q == job_i.cnt - 2'd1);
  assign status = fin && job_i.abort;
  assign pop_o  = load && fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
      end else if (out_ch_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= status ? 8'h00 : job_i.bytes[idx_q];
      bvalid_q   <= !status;
      run_last_q <= fin;
      end_q      <= fin && job_i.str_end;
      abort_q    <= status;
      len_q      <= fin ? job_i.len : '0;
    end
  end

  assign out_ch_o.valid      = valid_q;
  assign out_ch_o.out_byte   = byte_q;
  assign out_ch_o.byte_valid = bvalid_q;
  assign out_ch_o.run_last   = run_last_q;
  assign out_ch_o.string_end = end_q;
  assign out_ch_o.aborted    = abort_q;
  assign out_ch_o.out_length = len_q;

endmodule

// ===== sv/eks_checker.sv =====
// Port-level checks of the string escaper, bound to the top level.
// Depends on eks_pkg and the assertion macro header.
`include "euc_kr_aware_string_escaper_core_macros.svh"

module eks_checker import eks_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_i,
  input logic             ready_i,
  input logic [7:0]       out_byte_i,
  input logic             byte_valid_i,
  input logic             run_last_i,
  input logic             string_end_i,
  input logic             aborted_i,
  input logic [LEN_W-1:0] out_length_i
);

  `EKS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, valid_i && !ready_i, valid_i && $stable(out_byte_i) && $stable(out_length_i))
  `EKS_ASSERT_NOW(a_abort_beat, clk_i, rst_ni, valid_i && aborted_i, !byte_valid_i && string_end_i && run_last_i && out_length_i == '0 && out_byte_i == 8'h00)
  `EKS_ASSERT_NOW(a_status_is_abort, clk_i, rst_ni, valid_i && !byte_valid_i, aborted_i)
  `EKS_ASSERT_NOW(a_len_at_end, clk_i, rst_ni, valid_i && out_length_i != '0, string_end_i && run_last_i && out_length_i <= LEN_TOP)

endmodule

bind euc_kr_aware_string_escaper_core eks_checker u_eks_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (out_ch_o.valid),
  .ready_i      (out_ch_o.ready),
  .out_byte_i   (out_ch_o.out_byte),
  .byte_valid_i (out_ch_o.byte_valid),
  .run_last_i   (out_ch_o.run_last),
  .string_end_i (out_ch_o.string_end),
  .aborted_i    (out_ch_o.aborted),
  .out_length_i (out_ch_o.out_length)
);
